// ----- hw/rtl/pte_pkg.sv -----
// Package: types, phase and event codes for the publish header topic extractor.
`timescale 1ns / 1ps
package pte_pkg;

	localparam int unsigned MAX_LENGTH_BYTES = 4;

	localparam int unsigned LEN_W   = 28;
	localparam int unsigned LCNT_W  = 3;
	localparam int unsigned TLEN_W  = 16;
	localparam int unsigned PHASE_W = 3;
	localparam int unsigned EV_W    = 3;

	localparam logic [PHASE_W-1:0] PH_HEADER    = 3'd0;
	localparam logic [PHASE_W-1:0] PH_LENGTH    = 3'd1;
	localparam logic [PHASE_W-1:0] PH_TLEN_HI   = 3'd2;
	localparam logic [PHASE_W-1:0] PH_TLEN_LO   = 3'd3;
	localparam logic [PHASE_W-1:0] PH_TOPIC     = 3'd4;
	localparam logic [PHASE_W-1:0] PH_PAYLOAD   = 3'd5;
	localparam logic [PHASE_W-1:0] PH_MALFORMED = 3'd6;

	localparam logic [EV_W-1:0] EV_HEADER    = 3'd0;
	localparam logic [EV_W-1:0] EV_LEN_CONT  = 3'd1;
	localparam logic [EV_W-1:0] EV_LEN_DONE  = 3'd2;
	localparam logic [EV_W-1:0] EV_TLEN      = 3'd3;
	localparam logic [EV_W-1:0] EV_TOPIC     = 3'd4;
	localparam logic [EV_W-1:0] EV_PAYLOAD   = 3'd5;
	localparam logic [EV_W-1:0] EV_MALFORMED = 3'd6;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [LEN_W-1:0]   len_acc;
		logic [LCNT_W-1:0]  len_cnt;
		logic [TLEN_W-1:0]  tlen;
		logic [TLEN_W-1:0]  tcnt;
	} state_t;

	typedef struct packed {
		logic [EV_W-1:0]   event_res;
		logic [7:0]        topic_char;
		logic              last_topic;
		logic [LEN_W-1:0]  remaining_length;
		logic [LCNT_W-1:0] length_size;
		logic [TLEN_W-1:0] topic_length;
	} res_t;

endpackage

// ----- hw/rtl/pte_in_if.sv -----
// Interface: input byte channel with valid/ready handshake.
`timescale 1ns / 1ps
interface pte_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_req;

	modport source (output valid, output data_byte, output start_req, input ready);
	modport sink (input valid, input data_byte, input start_req, output ready);
endinterface

// ----- hw/rtl/pte_out_if.sv -----
// Interface: result channel with valid/ready handshake.
`timescale 1ns / 1ps
interface pte_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic [7:0]  topic_char;
	logic        last_topic;
	logic [27:0] remaining_length;
	logic [2:0]  length_size;
	logic [15:0] topic_length;

	modport source (output valid, output event_res, output topic_char, output last_topic,
		output remaining_length, output length_size, output topic_length, input ready);
	modport sink (input valid, input event_res, input topic_char, input last_topic,
		input remaining_length, input length_size, input topic_length, output ready);
endinterface

// ----- hw/rtl/pte_step.sv -----
// Per-byte decode: next parser state and result word from current state and byte.
`timescale 1ns / 1ps
module pte_step (
	input  pte_pkg::state_t st,
	input  logic [7:0]      data_byte,
	input  logic            start_req,
	output pte_pkg::state_t st_nxt,
	output pte_pkg::res_t   res
);
	import pte_pkg::*;

	logic [LEN_W-1:0]  addend;
	logic [TLEN_W-1:0] tcnt_inc;

	always_comb begin
		case (st.len_cnt[1:0])
			2'd0:    addend = {21'd0, data_byte[6:0]};
			2'd1:    addend = {14'd0, data_byte[6:0], 7'd0};
			2'd2:    addend = {7'd0, data_byte[6:0], 14'd0};
			default: addend = {data_byte[6:0], 21'd0};
		endcase
	end

	assign tcnt_inc = st.tcnt + 16'd1;

	always_comb begin
		st_nxt         = st;
		res            = '0;
		res.event_res  = EV_MALFORMED;
		if (start_req || st.phase == PH_HEADER) begin
			st_nxt        = '0;
			st_nxt.phase  = PH_LENGTH;
			res.event_res = EV_HEADER;
		end else begin
			unique case (st.phase)
				PH_LENGTH: begin
					if (st.len_cnt >= LCNT_W'(MAX_LENGTH_BYTES)) begin
						st_nxt.phase  = PH_MALFORMED;
						res.event_res = EV_MALFORMED;
					end else begin
						st_nxt.len_acc = st.len_acc + addend;
						st_nxt.len_cnt = st.len_cnt + 3'd1;
						if (data_byte[7]) begin
							res.event_res = EV_LEN_CONT;
						end else begin
							res.event_res = EV_LEN_DONE;
							st_nxt.phase  = PH_TLEN_HI;
						end
					end
				end
				PH_TLEN_HI: begin
					st_nxt.tlen   = {data_byte, 8'h00};
					st_nxt.phase  = PH_TLEN_LO;
					res.event_res = EV_TLEN;
				end
				PH_TLEN_LO: begin
					st_nxt.tlen   = st.tlen | {8'h00, data_byte};
					st_nxt.tcnt   = '0;
					res.event_res = EV_TLEN;
					st_nxt.phase  = ((st.tlen | {8'h00, data_byte}) == '0) ? PH_PAYLOAD : PH_TOPIC;
				end
				PH_TOPIC: begin
					res.event_res  = EV_TOPIC;
					res.topic_char = data_byte;
					st_nxt.tcnt    = tcnt_inc;
					if (tcnt_inc >= st.tlen) begin
						res.last_topic = 1'b1;
						st_nxt.phase   = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					res.event_res = EV_PAYLOAD;
				end
				default: begin
					st_nxt.phase  = PH_MALFORMED;
					res.event_res = EV_MALFORMED;
				end
			endcase
		end
		res.remaining_length = st_nxt.len_acc;
		res.length_size      = st_nxt.len_cnt;
		res.topic_length     = (st_nxt.phase == PH_TOPIC || st_nxt.phase == PH_PAYLOAD) ?
			st_nxt.tlen : '0;
	end
endmodule

// ----- hw/rtl/publish_header_topic_extractor_core.sv -----
// Top level: input register, per-byte decode, parser state and result register.
// A word is held in the input register, then decoded; its result is registered once the result register is free.
// Throughput: one word per cycle while results are taken; the result register frees as it is taken.
// Decode is one pass of the step logic between input and result registers.
// Reset clears valids and returns the parser to the header phase, all counts zero.
`timescale 1ns / 1ps
module publish_header_topic_extractor_core (
	input  logic clk,
	input  logic arst_n,
	pte_in_if.sink    pkt,
	pte_out_if.source tag
);
	import pte_pkg::*;

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          start_s1;
	logic          adv_s1;
	logic          out_valid_q;
	state_t        state_q;
	state_t        state_nxt;
	res_t          res_nxt;
	res_t          res_q;

	assign adv_s1    = valid_s1 && (!out_valid_q || tag.ready);
	assign pkt.ready = !valid_s1 || adv_s1;

	// hold input word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.ready) begin
			valid_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.ready && pkt.valid) begin
			byte_s1  <= pkt.data_byte;
			start_s1 <= pkt.start_req;
		end
	end

	pte_step u_step (
		.st        (state_q),
		.data_byte (byte_s1),
		.start_req (start_s1),
		.st_nxt    (state_nxt),
		.res       (res_nxt)
	);

	// advance parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_HEADER, len_acc: '0, len_cnt: '0, tlen: '0, tcnt: '0};
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (tag.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= res_nxt;
		end
	end

	assign tag.valid            = out_valid_q;
	assign tag.event_res        = res_q.event_res;
	assign tag.topic_char       = res_q.topic_char;
	assign tag.last_topic       = res_q.last_topic;
	assign tag.remaining_length = res_q.remaining_length;
	assign tag.length_size      = res_q.length_size;
	assign tag.topic_length     = res_q.topic_length;

`ifndef SYNTHESIS
	a_start_gives_header: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && start_s1 |=> out_valid_q && res_q.event_res == EV_HEADER)
		else $error("start word did not give a header event");

	a_malformed_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && !start_s1 && state_q.phase == PH_MALFORMED
		|=> res_q.event_res == EV_MALFORMED && state_q.phase == PH_MALFORMED)
		else $error("malformed phase left without a start");

	a_last_is_topic: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.last_topic |-> res_q.event_res == EV_TOPIC)
		else $error("last topic flag on a non-topic event");

	a_len_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> res_q.length_size <= LCNT_W'(MAX_LENGTH_BYTES))
		else $error("length size beyond limit");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(state_q))
		else $error("parser state changed without a word");
`endif
endmodule
